/* hw/rtl/ray_capped_cylinder_hit_test_unit_defines.svh */
// assertion macros for the rtl top module
`ifndef RAY_CAPPED_CYLINDER_HIT_TEST_UNIT_DEFINES_SVH
`define RAY_CAPPED_CYLINDER_HIT_TEST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define RCC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rcc assertion failed");
// checked at every edge, reset included
`define RCC_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rcc reset assertion failed");
`else
`define RCC_ASSERT(lbl, clk, rstn, prop)
`define RCC_ASSERT_RST(lbl, clk, prop)
`endif

`endif

/* hw/rtl/rcc_pkg.sv */
`default_nettype none

package rcc_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned PADDR_W       = 5;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_BASE_Z   = 3'd2,
    REG_HEIGHT   = 3'd3,
    REG_RADIUS   = 3'd4
  } reg_idx_e;

  typedef logic signed [31:0] fix_t;

  typedef struct packed {
    fix_t origin_x;
    fix_t origin_y;
    fix_t origin_z;
    fix_t dir_x;
    fix_t dir_y;
    fix_t dir_z;
  } ray_t;

  typedef struct packed {
    logic hit;
  } hit_t;

  function automatic fix_t sat33(input logic signed [32:0] v);
    fix_t res;
    if (v[32] != v[31]) begin
      res = v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic fix_t sat64(input logic signed [63:0] v);
    fix_t res;
    if (v > 64'sh000000007FFFFFFF) begin
      res = 32'sh7FFFFFFF;
    end else if (v < 64'shFFFFFFFF80000000) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic fix_t fx_add(input fix_t a, input fix_t b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    return sat33(s);
  endfunction

  function automatic fix_t fx_sub(input fix_t a, input fix_t b);
    logic signed [32:0] s;
    s = 33'(a) - 33'(b);
    return sat33(s);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rcc_if.sv */
`default_nettype none

interface rcc_ray_if;
  logic          valid;
  logic          ready;
  rcc_pkg::ray_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rcc_hit_if;
  logic          valid;
  logic          ready;
  rcc_pkg::hit_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rcc_sqrt.sv */
`default_nettype none

// pipelined integer square root of rad * 2^FRAC_BITS, one result bit per stage
module rcc_sqrt #(
  parameter int unsigned FRAC_BITS = rcc_pkg::FRAC_BITS_DEF,
  parameter int unsigned SB_W      = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [SB_W-1:0]   sb_i,
  input  wire rcc_pkg::fix_t     rad_i,
  output logic                   valid_o,
  output logic [SB_W-1:0]        sb_o,
  output rcc_pkg::fix_t          root_o
);

  localparam int unsigned NW = 31 + FRAC_BITS;
  localparam int unsigned RB = (NW + 1) / 2;
  localparam int unsigned PW = 2 * RB;

  typedef struct packed {
    logic [RB-1:0] rem;
    logic [RB-1:0] root;
    logic [PW-1:0] n;
  } st_t;

  st_t             st_q  [RB+1];
  st_t             st_d  [RB+1];
  logic [SB_W-1:0] sb_q  [RB+1];
  logic [RB:0]     valid_q;

  always_comb begin
    logic [RB+1:0] r;
    logic [RB+1:0] trial;
    logic          ge;
    // negative radicand never reaches a used root, treat as zero
    st_d[0].rem  = '0;
    st_d[0].root = '0;
    st_d[0].n    = rad_i[31] ? '0 : PW'({rad_i[30:0], {FRAC_BITS{1'b0}}});
    for (int k = 0; k < RB; k++) begin
      r     = {st_q[k].rem, st_q[k].n[PW-1 -: 2]};
      trial = {st_q[k].root, 2'b01};
      ge    = (r >= trial);
      st_d[k+1].rem  = ge ? RB'(r - trial) : r[RB-1:0];
      st_d[k+1].root = {st_q[k].root[RB-2:0], ge};
      st_d[k+1].n    = {st_q[k].n[PW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[RB-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= st_d[0];
      sb_q[0] <= sb_i;
      for (int k = 1; k <= RB; k++) begin
        st_q[k] <= st_d[k];
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  assign valid_o = valid_q[RB];
  assign sb_o    = sb_q[RB];
  assign root_o  = 32'(st_q[RB].root);

endmodule

`default_nettype wire

/* hw/rtl/rcc_div.sv */
`default_nettype none

// pipelined saturating fixed point divide (num * 2^FRAC_BITS) / den,
// truncated toward zero, one quotient bit per stage, several lanes in step
module rcc_div #(
  parameter int unsigned FRAC_BITS = rcc_pkg::FRAC_BITS_DEF,
  parameter int unsigned LANES     = 4,
  parameter int unsigned SB_W      = 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [SB_W-1:0] sb_i,
  input  wire rcc_pkg::fix_t   num_i [LANES],
  input  wire rcc_pkg::fix_t   den_i [LANES],
  output logic                 valid_o,
  output logic [SB_W-1:0]      sb_o,
  output rcc_pkg::fix_t        quo_o [LANES]
);

  localparam int unsigned NW    = 32 + FRAC_BITS;
  localparam int unsigned STEPS = 32;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
    logic [31:0] den;
    logic        neg;
    logic        ovf;
  } lane_t;

  lane_t           ln_q  [STEPS+1][LANES];
  lane_t           ln_d  [STEPS+1][LANES];
  logic [SB_W-1:0] sb_q  [STEPS+1];
  logic [STEPS:0]  valid_q;

  rcc_pkg::fix_t   quo_d [LANES];
  rcc_pkg::fix_t   quo_q [LANES];
  logic [SB_W-1:0] out_sb_q;
  logic            out_valid_q;

  always_comb begin
    logic [31:0]   an;
    logic [31:0]   ad;
    logic [NW-1:0] n;
    logic [32:0]   r;
    logic          ge;
    lane_t         fin;
    for (int l = 0; l < LANES; l++) begin
      an = num_i[l][31] ? 32'(-num_i[l]) : 32'(num_i[l]);
      ad = den_i[l][31] ? 32'(-den_i[l]) : 32'(den_i[l]);
      n  = {an, {FRAC_BITS{1'b0}}};
      // quotient needs more than 32 bits when the high part reaches the divisor
      ln_d[0][l].ovf = (32'(n[NW-1:32]) >= ad);
      ln_d[0][l].rem = 32'(n[NW-1:32]);
      ln_d[0][l].low = n[31:0];
      ln_d[0][l].quo = '0;
      ln_d[0][l].den = ad;
      ln_d[0][l].neg = num_i[l][31] ^ den_i[l][31];
    end
    for (int k = 0; k < STEPS; k++) begin
      for (int l = 0; l < LANES; l++) begin
        r  = {ln_q[k][l].rem, ln_q[k][l].low[31]};
        ge = (r >= {1'b0, ln_q[k][l].den});
        ln_d[k+1][l]     = ln_q[k][l];
        ln_d[k+1][l].rem = ge ? 32'(r - {1'b0, ln_q[k][l].den}) : r[31:0];
        ln_d[k+1][l].low = {ln_q[k][l].low[30:0], 1'b0};
        ln_d[k+1][l].quo = {ln_q[k][l].quo[30:0], ge};
      end
    end
    for (int l = 0; l < LANES; l++) begin
      fin = ln_q[STEPS][l];
      if (fin.neg) begin
        quo_d[l] = (fin.ovf || fin.quo > 32'h80000000) ? 32'sh80000000 : 32'(-fin.quo);
      end else begin
        quo_d[l] = (fin.ovf || fin.quo[31]) ? 32'sh7FFFFFFF : fin.quo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q     <= {valid_q[STEPS-1:0], valid_i};
      out_valid_q <= valid_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q[0] <= sb_i;
      for (int l = 0; l < LANES; l++) begin
        ln_q[0][l] <= ln_d[0][l];
        quo_q[l]   <= quo_d[l];
      end
      for (int k = 1; k <= STEPS; k++) begin
        sb_q[k] <= sb_q[k-1];
        for (int l = 0; l < LANES; l++) begin
          ln_q[k][l] <= ln_d[k][l];
        end
      end
      out_sb_q <= sb_q[STEPS];
    end
  end

  assign valid_o = out_valid_q;
  assign sb_o    = out_sb_q;
  assign quo_o   = quo_q;

endmodule

`default_nettype wire

/* hw/rtl/ray_capped_cylinder_hit_test_unit.sv */
// Ray against capped z-axis cylinder hit tester. One ray (origin, direction,
// signed fixed point with FRAC_BITS fraction bits, Q16.16 by default) enters
// per clock and one hit bit leaves per ray, in order. The pipeline holds five
// stages of products and sums for the quadratic, the square root of the
// discriminant at one root bit per stage, one stage for the root numerators,
// a 34 stage divider that works out both cap distances and both side roots
// together at one quotient bit per stage, three stages of hit checks and the
// output register. When the output word is not taken the whole pipeline holds
// and the input is not ready. Cylinder registers sit on the APB port; the user
// must write them only while no ray is in flight, which the block itself does
// not enforce.
`default_nettype none
`include "ray_capped_cylinder_hit_test_unit_defines.svh"

module ray_capped_cylinder_hit_test_unit #(
  parameter int unsigned FRAC_BITS = rcc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  rcc_ray_if.sink                          ray_i,
  rcc_hit_if.source                        hit_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rcc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  typedef rcc_pkg::fix_t fix_t;

  typedef struct packed {
    fix_t ox;
    fix_t oy;
    fix_t oz;
    fix_t dx;
    fix_t dy;
    fix_t dz;
  } geo_t;

  typedef struct packed {
    geo_t g;
    fix_t a;
    fix_t hb;
    fix_t numb;
    fix_t numt;
    logic disc_neg;
  } sq_sb_t;

  typedef struct packed {
    geo_t g;
    logic disc_neg;
    logic dz_zero;
    logic a_zero;
  } dv_sb_t;

  localparam int unsigned SQ_SB_W   = $bits(sq_sb_t);
  localparam int unsigned DV_SB_W   = $bits(dv_sb_t);
  localparam int unsigned DIV_LANES = 4;
  localparam int unsigned L_CAP_B   = 0;
  localparam int unsigned L_CAP_T   = 1;
  localparam int unsigned L_ROOT_N  = 2;
  localparam int unsigned L_ROOT_P  = 3;

  function automatic fix_t fx_mul(input fix_t a, input fix_t b);
    logic signed [63:0] p;
    p = a * b;
    return rcc_pkg::sat64(p >>> FRAC_BITS);
  endfunction

  // configuration registers
  fix_t        center_x_q;
  fix_t        center_y_q;
  fix_t        base_z_q;
  logic [30:0] height_q;
  logic [30:0] radius_q;
  fix_t        top_q;
  fix_t        r2_q;

  rcc_pkg::reg_idx_e idx;
  logic              cfg_wr;

  assign idx    = rcc_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      base_z_q   <= '0;
      height_q   <= 31'd65536;
      radius_q   <= 31'd65536;
    end else if (cfg_wr) begin
      unique case (idx)
        rcc_pkg::REG_CENTER_X: center_x_q <= pwdata;
        rcc_pkg::REG_CENTER_Y: center_y_q <= pwdata;
        rcc_pkg::REG_BASE_Z:   base_z_q   <= pwdata;
        rcc_pkg::REG_HEIGHT:   height_q   <= pwdata[30:0];
        rcc_pkg::REG_RADIUS:   radius_q   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rcc_pkg::REG_CENTER_X: prdata = center_x_q;
      rcc_pkg::REG_CENTER_Y: prdata = center_y_q;
      rcc_pkg::REG_BASE_Z:   prdata = base_z_q;
      rcc_pkg::REG_HEIGHT:   prdata = {1'b0, height_q};
      rcc_pkg::REG_RADIUS:   prdata = {1'b0, radius_q};
      default:               prdata = '0;
    endcase
  end

  // derived cylinder values, settled long before a ray needs them
  always_ff @(posedge clk_i) begin
    top_q <= rcc_pkg::fx_add(base_z_q, fix_t'({1'b0, height_q}));
    r2_q  <= fx_mul(fix_t'({1'b0, radius_q}), fix_t'({1'b0, radius_q}));
  end

  // pipeline
  logic adv;
  logic out_valid_q;
  logic out_hit_q;

  assign adv         = !out_valid_q || hit_o.ready;
  assign ray_i.ready = adv;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v7_q, p1_v_q, p2_v_q, p3_v_q;
  geo_t g1_q, g2_q, g3_q, g4_q, g5_q;
  fix_t dxdx2_q, dydy2_q, oxdx2_q, oydy2_q, oxox2_q, oyoy2_q, numb2_q, numt2_q;
  fix_t a3_q, hb3_q, cs3_q, numb3_q, numt3_q;
  fix_t a4_q, hb4_q, c4_q, hh4_q, numb4_q, numt4_q;
  fix_t a5_q, hb5_q, hh5_q, ac5_q, numb5_q, numt5_q;

  fix_t   disc5;
  sq_sb_t sq_in;
  logic   v6;
  logic [SQ_SB_W-1:0] sb6_raw;
  sq_sb_t sb6;
  fix_t   root6;

  dv_sb_t sb7_q;
  fix_t   num7_q [DIV_LANES];
  fix_t   den7_q [DIV_LANES];
  fix_t   nhb6;

  logic   v8;
  logic [DV_SB_W-1:0] sb8_raw;
  dv_sb_t sb8;
  fix_t   q8 [DIV_LANES];

  dv_sb_t p1_sb_q, p2_sb_q, p3_sb_q;
  logic [DIV_LANES-1:0] p1_pos_q, p2_pos_q;
  fix_t   mxb1_q, myb1_q, mxt1_q, myt1_q, mz1_1_q, mz2_1_q;
  fix_t   pxb2_q, pyb2_q, pxt2_q, pyt2_q, z1_2_q, z2_2_q;
  fix_t   sxb3_q, syb3_q, sxt3_q, syt3_q;
  logic   capb_pos3_q, capt_pos3_q, side1_3_q, side2_3_q;
  logic   capb, capt, hit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v7_q        <= 1'b0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      p3_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= ray_i.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v7_q        <= v6;
      p1_v_q      <= v8;
      p2_v_q      <= p1_v_q;
      p3_v_q      <= p2_v_q;
      out_valid_q <= p3_v_q;
    end
  end

  // quadratic front end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      g1_q.ox <= rcc_pkg::fx_sub(ray_i.data.origin_x, center_x_q);
      g1_q.oy <= rcc_pkg::fx_sub(ray_i.data.origin_y, center_y_q);
      g1_q.oz <= ray_i.data.origin_z;
      g1_q.dx <= ray_i.data.dir_x;
      g1_q.dy <= ray_i.data.dir_y;
      g1_q.dz <= ray_i.data.dir_z;

      g2_q    <= g1_q;
      dxdx2_q <= fx_mul(g1_q.dx, g1_q.dx);
      dydy2_q <= fx_mul(g1_q.dy, g1_q.dy);
      oxdx2_q <= fx_mul(g1_q.ox, g1_q.dx);
      oydy2_q <= fx_mul(g1_q.oy, g1_q.dy);
      oxox2_q <= fx_mul(g1_q.ox, g1_q.ox);
      oyoy2_q <= fx_mul(g1_q.oy, g1_q.oy);
      numb2_q <= rcc_pkg::fx_sub(base_z_q, g1_q.oz);
      numt2_q <= rcc_pkg::fx_sub(top_q, g1_q.oz);

      g3_q    <= g2_q;
      a3_q    <= rcc_pkg::fx_add(dxdx2_q, dydy2_q);
      hb3_q   <= rcc_pkg::fx_add(oxdx2_q, oydy2_q);
      cs3_q   <= rcc_pkg::fx_add(oxox2_q, oyoy2_q);
      numb3_q <= numb2_q;
      numt3_q <= numt2_q;

      g4_q    <= g3_q;
      a4_q    <= a3_q;
      hb4_q   <= hb3_q;
      c4_q    <= rcc_pkg::fx_sub(cs3_q, r2_q);
      hh4_q   <= fx_mul(hb3_q, hb3_q);
      numb4_q <= numb3_q;
      numt4_q <= numt3_q;

      g5_q    <= g4_q;
      a5_q    <= a4_q;
      hb5_q   <= hb4_q;
      hh5_q   <= hh4_q;
      ac5_q   <= fx_mul(a4_q, c4_q);
      numb5_q <= numb4_q;
      numt5_q <= numt4_q;
    end
  end

  assign disc5          = rcc_pkg::fx_sub(hh5_q, ac5_q);
  assign sq_in.g        = g5_q;
  assign sq_in.a        = a5_q;
  assign sq_in.hb       = hb5_q;
  assign sq_in.numb     = numb5_q;
  assign sq_in.numt     = numt5_q;
  assign sq_in.disc_neg = disc5[31];

  rcc_sqrt #(
    .FRAC_BITS (FRAC_BITS),
    .SB_W      (SQ_SB_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v5_q),
    .sb_i    (sq_in),
    .rad_i   (disc5),
    .valid_o (v6),
    .sb_o    (sb6_raw),
    .root_o  (root6)
  );

  assign sb6  = sq_sb_t'(sb6_raw);
  assign nhb6 = rcc_pkg::fx_sub('0, sb6.hb);

  // numerators of the four divisions
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb7_q.g                <= sb6.g;
      sb7_q.disc_neg         <= sb6.disc_neg;
      sb7_q.dz_zero          <= (sb6.g.dz == '0);
      sb7_q.a_zero           <= (sb6.a == '0);
      num7_q[L_CAP_B]        <= sb6.numb;
      den7_q[L_CAP_B]        <= sb6.g.dz;
      num7_q[L_CAP_T]        <= sb6.numt;
      den7_q[L_CAP_T]        <= sb6.g.dz;
      num7_q[L_ROOT_N]       <= rcc_pkg::fx_sub(nhb6, root6);
      den7_q[L_ROOT_N]       <= sb6.a;
      num7_q[L_ROOT_P]       <= rcc_pkg::fx_add(nhb6, root6);
      den7_q[L_ROOT_P]       <= sb6.a;
    end
  end

  rcc_div #(
    .FRAC_BITS (FRAC_BITS),
    .LANES     (DIV_LANES),
    .SB_W      (DV_SB_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v7_q),
    .sb_i    (sb7_q),
    .num_i   (num7_q),
    .den_i   (den7_q),
    .valid_o (v8),
    .sb_o    (sb8_raw),
    .quo_o   (q8)
  );

  assign sb8 = dv_sb_t'(sb8_raw);

  // hit checks on the four distances
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_sb_q <= sb8;
      for (int l = 0; l < DIV_LANES; l++) begin
        p1_pos_q[l] <= (q8[l] > 32'sd0);
      end
      mxb1_q  <= fx_mul(sb8.g.dx, q8[L_CAP_B]);
      myb1_q  <= fx_mul(sb8.g.dy, q8[L_CAP_B]);
      mxt1_q  <= fx_mul(sb8.g.dx, q8[L_CAP_T]);
      myt1_q  <= fx_mul(sb8.g.dy, q8[L_CAP_T]);
      mz1_1_q <= fx_mul(sb8.g.dz, q8[L_ROOT_N]);
      mz2_1_q <= fx_mul(sb8.g.dz, q8[L_ROOT_P]);

      p2_sb_q  <= p1_sb_q;
      p2_pos_q <= p1_pos_q;
      pxb2_q   <= rcc_pkg::fx_add(p1_sb_q.g.ox, mxb1_q);
      pyb2_q   <= rcc_pkg::fx_add(p1_sb_q.g.oy, myb1_q);
      pxt2_q   <= rcc_pkg::fx_add(p1_sb_q.g.ox, mxt1_q);
      pyt2_q   <= rcc_pkg::fx_add(p1_sb_q.g.oy, myt1_q);
      z1_2_q   <= rcc_pkg::fx_add(p1_sb_q.g.oz, mz1_1_q);
      z2_2_q   <= rcc_pkg::fx_add(p1_sb_q.g.oz, mz2_1_q);

      p3_sb_q     <= p2_sb_q;
      sxb3_q      <= fx_mul(pxb2_q, pxb2_q);
      syb3_q      <= fx_mul(pyb2_q, pyb2_q);
      sxt3_q      <= fx_mul(pxt2_q, pxt2_q);
      syt3_q      <= fx_mul(pyt2_q, pyt2_q);
      capb_pos3_q <= p2_pos_q[L_CAP_B];
      capt_pos3_q <= p2_pos_q[L_CAP_T];
      side1_3_q   <= p2_pos_q[L_ROOT_N] && (z1_2_q >= base_z_q) && (z1_2_q <= top_q);
      side2_3_q   <= p2_pos_q[L_ROOT_P] && (z2_2_q >= base_z_q) && (z2_2_q <= top_q);
    end
  end

  assign capb  = capb_pos3_q && (rcc_pkg::fx_add(sxb3_q, syb3_q) <= r2_q);
  assign capt  = capt_pos3_q && (rcc_pkg::fx_add(sxt3_q, syt3_q) <= r2_q);
  // cap hits need a z direction, side hits a nonzero a
  assign hit_d = !p3_sb_q.disc_neg &&
                 ((!p3_sb_q.dz_zero && (capb || capt)) ||
                  (!p3_sb_q.a_zero && (side1_3_q || side2_3_q)));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_hit_q <= hit_d;
    end
  end

  assign hit_o.valid    = out_valid_q;
  assign hit_o.data.hit = out_hit_q;

  `RCC_ASSERT(a_stall_blocks_input, clk_i, rst_ni, hit_o.valid && !hit_o.ready |-> !ray_i.ready)
  `RCC_ASSERT(a_accept_enters, clk_i, rst_ni, ray_i.valid && ray_i.ready |=> v1_q)
  `RCC_ASSERT(a_front_holds, clk_i, rst_ni, !adv |=> $stable(g1_q) && $stable(v1_q))
  `RCC_ASSERT_RST(a_reset_empty, clk_i, !rst_ni |=> !hit_o.valid)

endmodule

`default_nettype wire

/* dv/ray_capped_cylinder_hit_test_unit_checker.sv */
`timescale 1ns / 100ps

module ray_capped_cylinder_hit_test_unit_checker
  import rcc_pkg::*;
#(
  parameter int unsigned FB = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  rcc_ray_if                 ray,
  rcc_hit_if                 hit,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_cnt_o,
  output int                 pending_o
);

  fix_t cyl_cx, cyl_cy, cyl_base, cyl_height, cyl_radius;
  logic hits_due[$];

  function automatic fix_t sat_q(logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic fix_t q_add(fix_t a, fix_t b);
    logic signed [63:0] s;
    s = a;
    s = s + b;
    return sat_q(s);
  endfunction

  function automatic fix_t q_sub(fix_t a, fix_t b);
    logic signed [63:0] s;
    s = a;
    s = s - b;
    return sat_q(s);
  endfunction

  // arithmetic shift gives the floor of the scaled product
  function automatic fix_t q_mul(fix_t a, fix_t b);
    logic signed [63:0] p;
    p = a;
    p = p * b;
    return sat_q(p >>> FB);
  endfunction

  function automatic fix_t q_div(fix_t a, fix_t b);
    logic signed [63:0] n, d;
    n = a;
    n = n <<< FB;
    d = b;
    return sat_q(n / d);
  endfunction

  function automatic fix_t q_sqrt(fix_t a);
    logic [63:0] n, res, bt;
    if (a <= 0) return 0;
    n = 64'(a) << FB;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return sat_q(res);
  endfunction

  function automatic logic disc_crosses(fix_t plane, fix_t ox, fix_t oy, fix_t oz,
                                        fix_t dx, fix_t dy, fix_t dz, fix_t r2);
    fix_t t, px, py;
    t = q_div(q_sub(plane, oz), dz);
    if (t <= 0) return 1'b0;
    px = q_add(ox, q_mul(dx, t));
    py = q_add(oy, q_mul(dy, t));
    return q_add(q_mul(px, px), q_mul(py, py)) <= r2;
  endfunction

  function automatic logic wall_crosses(fix_t t, fix_t oz, fix_t dz, fix_t top);
    fix_t z;
    if (t <= 0) return 1'b0;
    z = q_add(oz, q_mul(dz, t));
    return z >= cyl_base && z <= top;
  endfunction

  function automatic logic ray_meets_cylinder(ray_t r);
    fix_t ox, oy, top, r2, qa, hb, qc, disc, s, nhb;
    ox   = q_sub(r.origin_x, cyl_cx);
    oy   = q_sub(r.origin_y, cyl_cy);
    top  = q_add(cyl_base, cyl_height);
    r2   = q_mul(cyl_radius, cyl_radius);
    qa   = q_add(q_mul(r.dir_x, r.dir_x), q_mul(r.dir_y, r.dir_y));
    hb   = q_add(q_mul(ox, r.dir_x), q_mul(oy, r.dir_y));
    qc   = q_sub(q_add(q_mul(ox, ox), q_mul(oy, oy)), r2);
    disc = q_sub(q_mul(hb, hb), q_mul(qa, qc));
    if (disc < 0) return 1'b0;
    if (r.dir_z != 0) begin
      if (disc_crosses(cyl_base, ox, oy, r.origin_z, r.dir_x, r.dir_y, r.dir_z, r2))
        return 1'b1;
      if (disc_crosses(top, ox, oy, r.origin_z, r.dir_x, r.dir_y, r.dir_z, r2))
        return 1'b1;
    end
    // parallel to the axis: only a cap can be met
    if (qa == 0) return 1'b0;
    s   = q_sqrt(disc);
    nhb = q_sub(0, hb);
    if (wall_crosses(q_div(q_sub(nhb, s), qa), r.origin_z, r.dir_z, top)) return 1'b1;
    return wall_crosses(q_div(q_add(nhb, s), qa), r.origin_z, r.dir_z, top);
  endfunction

  assign pending_o = hits_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyl_cx     <= 0;
      cyl_cy     <= 0;
      cyl_base   <= 0;
      cyl_height <= 32'sd65536;
      cyl_radius <= 32'sd65536;
      fail_cnt_o <= 0;
      hits_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_CENTER_X: cyl_cx     <= pwdata;
          REG_CENTER_Y: cyl_cy     <= pwdata;
          REG_BASE_Z:   cyl_base   <= pwdata;
          REG_HEIGHT:   cyl_height <= {1'b0, pwdata[30:0]};
          REG_RADIUS:   cyl_radius <= {1'b0, pwdata[30:0]};
          default: ;
        endcase
      end
      if (ray.valid && ray.ready) hits_due.push_back(ray_meets_cylinder(ray.data));
      if (hit.valid && hit.ready) begin
        if (hits_due.size() == 0) begin
          $error("hit word with nothing expected");
          fail_cnt_o <= fail_cnt_o + 1;
        end else if (hit.data.hit !== hits_due[0]) begin
          $error("hit: expected %0b, actual %0b", hits_due[0], hit.data.hit);
          fail_cnt_o <= fail_cnt_o + 1;
          void'(hits_due.pop_front());
        end else begin
          void'(hits_due.pop_front());
        end
      end
    end
  end

endmodule

/* dv/ray_capped_cylinder_hit_test_unit_tb.sv */
`timescale 1ns / 100ps

module ray_capped_cylinder_hit_test_unit_tb;
  import rcc_pkg::*;

  localparam int unsigned ONE = 65536;

  logic               clk_i;
  logic               rst_ni;
  logic               psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_cnt, pending;
  bit                 hold_req;

  rcc_ray_if ray ();
  rcc_hit_if hit ();

  ray_capped_cylinder_hit_test_unit uut (
    .clk_i, .rst_ni, .ray_i(ray), .hit_o(hit),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ray_capped_cylinder_hit_test_unit_checker chk (
    .clk_i, .rst_ni, .ray, .hit, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // local copy of the cylinder, used to aim rays
  int cyl_cx, cyl_cy, cyl_base, cyl_h, cyl_r;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver side
  initial begin
    int g;
    hit.ready = 1'b0;
    forever begin
      if (hold_req) begin
        hit.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end
      g = pick_gap();
      if (g > 0) begin
        hit.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      hit.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  end

  task automatic reg_write(reg_idx_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_cylinder(int cx, int cy, int bz, int h, int r);
    drain();
    reg_write(REG_CENTER_X, cx);
    reg_write(REG_CENTER_Y, cy);
    reg_write(REG_BASE_Z, bz);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_RADIUS, r);
    cyl_cx = cx; cyl_cy = cy; cyl_base = bz;
    cyl_h = h & 32'h7FFFFFFF; cyl_r = r & 32'h7FFFFFFF;
  endtask

  task automatic send_ray(ray_t r);
    int g;
    g = pick_gap();
    if (g > 0) begin
      ray.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    ray.valid <= 1'b1;
    ray.data  <= r;
    do @(posedge clk_i); while (!ray.ready);
  endtask

  function automatic ray_t mk(int ox, int oy, int oz, int dx, int dy, int dz);
    ray_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    return r;
  endfunction

  function automatic fix_t clip(longint v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return fix_t'(v);
  endfunction

  function automatic int rnd_signed(int unsigned mag);
    return int'($urandom_range(0, 2 * mag)) - int'(mag);
  endfunction

  // aim at a point near the cylinder, start a few steps back along the ray
  function automatic ray_t aimed_ray();
    longint tx, ty, tz, k, span;
    int dx, dy, dz;
    ray_t r;
    span = longint'(cyl_r) * 3 / 2 + ONE / 4;
    if (span > 64'sd1 << 30) span = 64'sd1 << 30;
    tx = cyl_cx + longint'(rnd_signed(int'(span)));
    ty = cyl_cy + longint'(rnd_signed(int'(span)));
    tz = cyl_base + longint'(cyl_h) / 2 +
         longint'(rnd_signed(int'((longint'(cyl_h) * 4 / 5 + ONE / 4) & 32'h3FFFFFFF)));
    dx = rnd_signed(4 * ONE);
    dy = rnd_signed(4 * ONE);
    dz = rnd_signed(4 * ONE);
    case ($urandom_range(0, 7))
      0: dz = 0;
      1: begin dx = 0; dy = 0; end
      2: dx = 0;
      default: ;
    endcase
    k = $urandom_range(1, 8);
    r = mk(clip(tx - k * dx), clip(ty - k * dy), clip(tz - k * dz), dx, dy, dz);
    // sometimes a broken one: pointing the other way
    if ($urandom_range(0, 9) == 0) begin
      r.dir_x = -dx; r.dir_y = -dy; r.dir_z = -dz;
    end
    return r;
  endfunction

  function automatic ray_t noise_ray();
    return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic random_rays(int n, bit pressure);
    for (int i = 0; i < n; i++) begin
      if (pressure && i == n / 3) hold_req = 1'b1;
      if (pressure && i == 2 * n / 3) begin
        while (pending != 0) begin
          ray.valid <= 1'b0;
          @(posedge clk_i);
        end
      end
      if ($urandom_range(0, 4) == 0) send_ray(noise_ray());
      else send_ray(aimed_ray());
    end
    ray.valid <= 1'b0;
  endtask

  initial begin
    localparam int MAXI = 32'h7FFFFFFF;
    localparam int MINI = 32'h80000000;
    hold_req   = 1'b0;
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    ray.valid  = 1'b0;
    ray.data   = '0;
    cyl_cx = 0; cyl_cy = 0; cyl_base = 0; cyl_h = ONE; cyl_r = ONE;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rays on the reset cylinder
    send_ray(mk(0, 0, -5 * ONE, 0, 0, ONE));             // up the axis, through caps
    send_ray(mk(0, 0, 5 * ONE, 0, 0, -ONE));             // down the axis
    send_ray(mk(0, 0, -5 * ONE, 0, 0, -ONE));            // along the axis, away
    send_ray(mk(2 * ONE, 0, -5 * ONE, 0, 0, ONE));       // parallel, outside
    send_ray(mk(-5 * ONE, 0, ONE / 2, ONE, 0, 0));       // side, flat in z
    send_ray(mk(-5 * ONE, 5 * ONE, ONE / 2, ONE, 0, 0)); // flat, misses
    send_ray(mk(-5 * ONE, 0, ONE / 2, -ONE, 0, 0));      // flat, away
    send_ray(mk(-5 * ONE, 0, 3 * ONE, ONE, 0, 0));       // flat, above the top
    send_ray(mk(-5 * ONE, 0, -3 * ONE, ONE, 0, ONE));    // slanted
    send_ray(mk(0, 0, ONE / 2, ONE, 0, 0));              // from inside
    send_ray(mk(ONE, 0, 0, 0, ONE, 0));                  // grazing the wall
    send_ray(mk(0, 0, 0, 0, 0, 0));                      // zero direction
    send_ray(mk(MAXI, MAXI, MAXI, MAXI, MAXI, MAXI));
    send_ray(mk(MINI, MINI, MINI, MINI, MINI, MINI));
    send_ray(mk(MINI, MAXI, MINI, MAXI, MINI, MAXI));
    send_ray(mk(0, 0, MINI, 0, 0, MAXI));
    send_ray(mk(MAXI, 0, 0, MINI, 0, 0));
    send_ray(mk(-1, -1, -1, 1, 1, 1));
    random_rays(200, 1'b1);

    set_cylinder(MAXI, MAXI, MAXI, MAXI, MAXI);
    random_rays(60, 1'b0);
    set_cylinder(MINI, MINI, MINI, 0, 0);
    random_rays(60, 1'b0);
    set_cylinder(0, 0, 0, 0, ONE);
    random_rays(80, 1'b0);
    set_cylinder($urandom, $urandom, $urandom, $urandom, $urandom);
    random_rays(50, 1'b0);
    for (int p = 0; p < 5; p++) begin
      set_cylinder(rnd_signed(16 * ONE), rnd_signed(16 * ONE), rnd_signed(16 * ONE),
                   $urandom_range(0, 16 * ONE), $urandom_range(0, 8 * ONE));
      random_rays(160, p == 2);
    end

    drain();
    if (fail_cnt == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
